// ----- rtl/core/amc_pkg.sv -----
// ----------------------------------------------------------------------------
// amc_pkg - shared definitions of the averaged moisture calibrator
// Widths, limits, register indexes and band codes used by the front end,
// the back end, the top level and the port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package amc_pkg;

	// default converter code width
	localparam int SAMPLE_BITS_DEF = 12;

	// millivolt readings and their batch total
	localparam int MV_BITS  = 12;
	localparam int MV_TOT_W = 20;

	// sample counter and batch size
	localparam int CNT_BITS = 8;
	localparam logic [CNT_BITS-1:0] DEFAULT_BATCH = 8'd20;

	// moisture percentage
	localparam int PCT_BITS     = 8;
	localparam int PCT_MAG_BITS = 7;
	localparam logic [PCT_MAG_BITS-1:0] FULL_SCALE  = 7'd100;
	localparam logic [PCT_MAG_BITS-1:0] DRY_LIMIT   = 7'd30;
	localparam logic [PCT_MAG_BITS-1:0] MOIST_LIMIT = 7'd70;
	localparam logic [PCT_BITS-1:0]     PCT_UNCAL   = 8'hFF;

	// batch queue between front and back end
	localparam int QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AIR   = 2'd0,
		CFG_WATER = 2'd1,
		CFG_BATCH = 2'd2
	} cfg_index_t;

	// moisture band codes
	typedef enum logic [1:0] {
		BAND_DRY   = 2'd0,
		BAND_MOIST = 2'd1,
		BAND_WET   = 2'd2,
		BAND_UNCAL = 2'd3
	} band_t;

	// band of a calibrated percentage
	function automatic band_t band_of(input logic [PCT_MAG_BITS-1:0] pct);
		band_t b;
		if (pct < DRY_LIMIT) begin
			b = BAND_DRY;
		end else if (pct < MOIST_LIMIT) begin
			b = BAND_MOIST;
		end else begin
			b = BAND_WET;
		end
		return b;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/amc_fifo.sv -----
// ----------------------------------------------------------------------------
// amc_fifo - short batch queue
// Holds finished batch snapshots between the accumulating front end and the
// dividing back end, so that each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module amc_fifo #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] dout,
	output logic                  full,
	output logic                  empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign full  = (fill_q == CNT_W'(DEPTH));
	assign empty = (fill_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/amc_div.sv -----
// ----------------------------------------------------------------------------
// amc_div - shared restoring divider
// Unsigned division, one quotient bit per cycle. A start pulse loads the
// operands; done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module amc_div #(
	parameter int DVD_W = 20,
	parameter int DSR_W = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DSR_W-1:0] divisor,
	output logic                  done,
	output logic      [DVD_W-1:0] quotient
);
	localparam int STEP_W = $clog2(DVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DSR_W-1:0]  rem_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DSR_W:0]    trial;
	logic              fits;

	assign done     = done_q;
	assign quotient = quo_q;

	// partial remainder with the next dividend bit
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	// operand and remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DSR_W'(trial - {1'b0, dsr_q}) : trial[DSR_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && (step_q == STEP_W'(DVD_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/amc_front.sv -----
// ----------------------------------------------------------------------------
// amc_front - sample accumulator
// Takes one sample per beat, keeps the batch totals, extremes and count, and
// pushes a snapshot of the batch into the queue when the batch is complete.
// Snapshot layout from the lowest bit: raw total, millivolt total, count,
// minimum raw code, maximum raw code.
// ----------------------------------------------------------------------------
`default_nettype none

module amc_front #(
	parameter int SAMPLE_BITS = amc_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [SAMPLE_BITS-1:0]           raw_sample,
	input  wire logic [amc_pkg::MV_BITS-1:0]      sample_millivolts,
	input  wire logic [amc_pkg::CNT_BITS-1:0]     samples_per_reading,
	input  wire logic                             queue_full,
	output logic                                  push,
	output logic [2*SAMPLE_BITS + amc_pkg::CNT_BITS + amc_pkg::MV_TOT_W
		+ SAMPLE_BITS + amc_pkg::CNT_BITS - 1:0] entry
);
	import amc_pkg::*;

	localparam int TOT_W = SAMPLE_BITS + CNT_BITS;

	logic [TOT_W-1:0]       raw_total_q;
	logic [MV_TOT_W-1:0]    mv_total_q;
	logic [SAMPLE_BITS-1:0] lowest_q;
	logic [SAMPLE_BITS-1:0] highest_q;
	logic [CNT_BITS-1:0]    count_q;

	logic                   accept;
	logic [TOT_W-1:0]       raw_total_n;
	logic [MV_TOT_W-1:0]    mv_total_n;
	logic [SAMPLE_BITS-1:0] lowest_n;
	logic [SAMPLE_BITS-1:0] highest_n;
	logic [CNT_BITS-1:0]    count_n;
	logic [CNT_BITS-1:0]    batch;
	logic                   batch_done;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// running values with this sample folded in
	assign raw_total_n = raw_total_q + TOT_W'(raw_sample);
	assign mv_total_n  = mv_total_q + MV_TOT_W'(sample_millivolts);
	assign lowest_n    = (raw_sample < lowest_q) ? raw_sample : lowest_q;
	assign highest_n   = (raw_sample > highest_q) ? raw_sample : highest_q;
	assign count_n     = count_q + 1'b1;

	// batch completion
	assign batch      = (samples_per_reading == '0) ? DEFAULT_BATCH : samples_per_reading;
	assign batch_done = (count_n >= batch);

	assign push  = accept && batch_done;
	assign entry = {highest_n, lowest_n, count_n, mv_total_n, raw_total_n};

	// batch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_total_q <= '0;
			mv_total_q  <= '0;
			lowest_q    <= '1;
			highest_q   <= '0;
			count_q     <= '0;
		end else if (accept) begin
			if (batch_done) begin
				raw_total_q <= '0;
				mv_total_q  <= '0;
				lowest_q    <= '1;
				highest_q   <= '0;
				count_q     <= '0;
			end else begin
				raw_total_q <= raw_total_n;
				mv_total_q  <= mv_total_n;
				lowest_q    <= lowest_n;
				highest_q   <= highest_n;
				count_q     <= count_n;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/amc_back.sv -----
// ----------------------------------------------------------------------------
// amc_back - batch evaluator
// Pops one batch snapshot, forms both means and the moisture percentage on
// the shared divider, classifies the band and holds the result in the
// output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module amc_back #(
	parameter int SAMPLE_BITS = amc_pkg::SAMPLE_BITS_DEF,
	parameter int DVD_W       = 20,
	parameter int ENT_W       = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// batch queue
	input  wire logic                           queue_empty,
	input  wire logic [ENT_W-1:0]               entry,
	output logic                                pop,
	// calibration points
	input  wire logic [SAMPLE_BITS-1:0]         air_point,
	input  wire logic [SAMPLE_BITS-1:0]         water_point,
	// shared divider
	output logic                                div_start,
	output logic [DVD_W-1:0]                    div_dividend,
	output logic [SAMPLE_BITS-1:0]              div_divisor,
	input  wire logic                           div_done,
	input  wire logic [DVD_W-1:0]               div_quotient,
	// result
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [SAMPLE_BITS-1:0]              avg_raw,
	output logic [amc_pkg::MV_BITS-1:0]         avg_millivolts,
	output logic [SAMPLE_BITS-1:0]              min_raw,
	output logic [SAMPLE_BITS-1:0]              max_raw,
	output logic                                calibration_ok,
	output logic [amc_pkg::PCT_BITS-1:0]        moisture_percent,
	output logic [1:0]                          moisture_band
);
	import amc_pkg::*;

	localparam int S      = SAMPLE_BITS;
	localparam int TOT_W  = S + CNT_BITS;
	localparam int PROD_W = S + PCT_MAG_BITS;

	typedef enum logic [2:0] {
		B_IDLE, B_RAW, B_MV, B_MUL, B_CAL, B_PCT, B_OUT
	} bstate_t;

	bstate_t state_q;

	// batch snapshot fields
	logic [TOT_W-1:0]    head_raw_tot;
	logic [MV_TOT_W-1:0] head_mv_tot;
	logic [CNT_BITS-1:0] head_cnt;
	logic [S-1:0]        head_low;
	logic [S-1:0]        head_high;

	logic [MV_TOT_W-1:0]     mv_tot_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic [S-1:0]            low_q, high_q;
	logic [S-1:0]            avg_raw_q;
	logic [MV_BITS-1:0]      avg_mv_q;
	logic [DVD_W-1:0]        mag_num_q;
	logic [S-1:0]            mag_den_q;
	logic                    num_neg_q, den_neg_q;
	logic                    ok_q;
	logic [PCT_MAG_BITS-1:0] pct_q;

	logic                    out_valid_q;
	logic [S-1:0]            out_avg_raw_q, out_min_q, out_max_q;
	logic [MV_BITS-1:0]      out_avg_mv_q;
	logic                    out_ok_q;
	logic [PCT_BITS-1:0]     out_pct_q;
	band_t                   out_band_q;

	logic [S:0]              diff_a, diff_d;
	logic [S-1:0]            mag_a, mag_d;
	logic [PROD_W-1:0]       prod;
	logic                    pct_needs_div;
	logic                    out_free;

	assign head_raw_tot = entry[0 +: TOT_W];
	assign head_mv_tot  = entry[TOT_W +: MV_TOT_W];
	assign head_cnt     = entry[TOT_W + MV_TOT_W +: CNT_BITS];
	assign head_low     = entry[TOT_W + MV_TOT_W + CNT_BITS +: S];
	assign head_high    = entry[TOT_W + MV_TOT_W + CNT_BITS + S +: S];

	// signed distances from the air point, as sign and magnitude
	assign diff_a = {1'b0, avg_raw_q} - {1'b0, air_point};
	assign diff_d = {1'b0, water_point} - {1'b0, air_point};
	assign mag_a  = diff_a[S] ? S'(-diff_a) : diff_a[S-1:0];
	assign mag_d  = diff_d[S] ? S'(-diff_d) : diff_d[S-1:0];
	assign prod   = PROD_W'(mag_a) * PROD_W'(FULL_SCALE);

	// a positive quotient only when both sides share a sign and are nonzero
	assign pct_needs_div = (mag_den_q != '0) && (num_neg_q == den_neg_q)
		&& (mag_num_q != '0);
	assign out_free      = !out_valid_q || out_ready;

	// queue pop and divider requests
	always_comb begin
		pop          = 1'b0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		unique case (state_q)
			B_IDLE: begin
				if (!queue_empty) begin
					pop          = 1'b1;
					div_start    = 1'b1;
					div_dividend = DVD_W'(head_raw_tot);
					div_divisor  = S'(head_cnt);
				end
			end
			B_RAW: begin
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = DVD_W'(mv_tot_q);
					div_divisor  = S'(cnt_q);
				end
			end
			B_CAL: begin
				if (pct_needs_div) begin
					div_start    = 1'b1;
					div_dividend = mag_num_q;
					div_divisor  = mag_den_q;
				end
			end
			default: begin
			end
		endcase
	end

	// evaluation sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// taken beat drops out unless a new one is loaded below
			if (out_valid_q && out_ready && state_q != B_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!queue_empty) begin
						mv_tot_q <= head_mv_tot;
						cnt_q    <= head_cnt;
						low_q    <= head_low;
						high_q   <= head_high;
						state_q  <= B_RAW;
					end
				end
				B_RAW: begin
					if (div_done) begin
						avg_raw_q <= div_quotient[S-1:0];
						state_q   <= B_MV;
					end
				end
				B_MV: begin
					if (div_done) begin
						avg_mv_q <= div_quotient[MV_BITS-1:0];
						state_q  <= B_MUL;
					end
				end
				B_MUL: begin
					mag_num_q <= DVD_W'(prod);
					num_neg_q <= diff_a[S];
					mag_den_q <= mag_d;
					den_neg_q <= diff_d[S];
					state_q   <= B_CAL;
				end
				B_CAL: begin
					ok_q  <= (mag_den_q != '0);
					pct_q <= '0;
					state_q <= pct_needs_div ? B_PCT : B_OUT;
				end
				B_PCT: begin
					if (div_done) begin
						pct_q <= (div_quotient > DVD_W'(FULL_SCALE)) ? FULL_SCALE
							: div_quotient[PCT_MAG_BITS-1:0];
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_avg_raw_q <= avg_raw_q;
						out_avg_mv_q  <= avg_mv_q;
						out_min_q     <= low_q;
						out_max_q     <= high_q;
						out_ok_q      <= ok_q;
						out_pct_q     <= ok_q ? {1'b0, pct_q} : PCT_UNCAL;
						out_band_q    <= ok_q ? band_of(pct_q) : BAND_UNCAL;
						state_q       <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign avg_raw          = out_avg_raw_q;
	assign avg_millivolts   = out_avg_mv_q;
	assign min_raw          = out_min_q;
	assign max_raw          = out_max_q;
	assign calibration_ok   = out_ok_q;
	assign moisture_percent = out_pct_q;
	assign moisture_band    = out_band_q;

endmodule

`default_nettype wire

// ----- rtl/core/averaged_moisture_calibrator_top.sv -----
// ----------------------------------------------------------------------------
// averaged_moisture_calibrator_top - averaging two-point moisture calibrator
// Averages batches of converter samples and maps the mean raw code onto a
// moisture percentage between the air and water calibration points.
// ----------------------------------------------------------------------------
// Samples are taken one per clock while the two-entry batch queue has room;
// each completed batch yields one result beat. The back end runs up to three
// divisions on one shared bit-serial divider of DVD_W = max(SAMPLE_BITS + 8,
// 20) steps (the mean raw code, the mean millivolts, the percentage); when
// the percentage needs no division (uncalibrated, or clamped to zero) only
// the two means are divided. The queue lets the front end take the samples
// of the next batch while the back end evaluates an earlier one, so long
// batches run at one sample per cycle while the results are taken; short ones
// are paced by the divider. Registers may be written only while no batch
// result is outstanding; they take effect on the next sample.
`default_nettype none

module averaged_moisture_calibrator_top #(
	parameter int SAMPLE_BITS = amc_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	// sample stream
	input  wire logic                                    s_axis_tvalid,
	output logic                                         s_axis_tready,
	// raw_sample, sample_millivolts
	input  wire logic [((SAMPLE_BITS + 12 + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// result stream
	output logic                                         m_axis_tvalid,
	input  wire logic                                    m_axis_tready,
	// avg_raw, avg_millivolts, min_raw, max_raw, calibration_ok,
	// moisture_percent, moisture_band
	output logic [((3 * SAMPLE_BITS + 23 + 7) / 8) * 8 - 1:0] m_axis_tdata,
	// register writes
	input  wire logic                                    cfg_we,
	input  wire logic [amc_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [SAMPLE_BITS-1:0]                  cfg_wdata
);
	import amc_pkg::*;

	localparam int S      = SAMPLE_BITS;
	localparam int OUT_W  = ((3 * SAMPLE_BITS + 23 + 7) / 8) * 8;
	localparam int TOT_W  = S + CNT_BITS;
	localparam int DVD_W  = (TOT_W > MV_TOT_W) ? TOT_W : MV_TOT_W;
	localparam int ENT_W  = 2 * S + CNT_BITS + MV_TOT_W + TOT_W;

	logic [S-1:0]        air_point_q;
	logic [S-1:0]        water_point_q;
	logic [CNT_BITS-1:0] batch_size_q;

	logic             q_push, q_pop, q_full, q_empty;
	logic [ENT_W-1:0] q_din, q_dout;

	logic             div_start, div_done;
	logic [DVD_W-1:0] div_dividend, div_quotient;
	logic [S-1:0]     div_divisor;

	logic                out_valid;
	logic [S-1:0]        avg_raw, min_raw, max_raw;
	logic [MV_BITS-1:0]  avg_millivolts;
	logic                calibration_ok;
	logic [PCT_BITS-1:0] moisture_percent;
	logic [1:0]          moisture_band;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			air_point_q   <= '1;
			water_point_q <= '0;
			batch_size_q  <= DEFAULT_BATCH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_AIR:   air_point_q   <= cfg_wdata;
				CFG_WATER: water_point_q <= cfg_wdata;
				CFG_BATCH: batch_size_q  <= cfg_wdata[CNT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// accumulating front end
	amc_front #(
		.SAMPLE_BITS(S)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (s_axis_tvalid),
		.in_ready           (s_axis_tready),
		.raw_sample         (s_axis_tdata[S-1:0]),
		.sample_millivolts  (s_axis_tdata[S +: MV_BITS]),
		.samples_per_reading(batch_size_q),
		.queue_full         (q_full),
		.push               (q_push),
		.entry              (q_din)
	);

	// batch queue
	amc_fifo #(
		.WIDTH(ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.pop   (q_pop),
		.dout  (q_dout),
		.full  (q_full),
		.empty (q_empty)
	);

	// shared divider
	amc_div #(
		.DVD_W(DVD_W),
		.DSR_W(S)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quotient)
	);

	// evaluating back end
	amc_back #(
		.SAMPLE_BITS(S),
		.DVD_W      (DVD_W),
		.ENT_W      (ENT_W)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.queue_empty     (q_empty),
		.entry           (q_dout),
		.pop             (q_pop),
		.air_point       (air_point_q),
		.water_point     (water_point_q),
		.div_start       (div_start),
		.div_dividend    (div_dividend),
		.div_divisor     (div_divisor),
		.div_done        (div_done),
		.div_quotient    (div_quotient),
		.out_valid       (out_valid),
		.out_ready       (m_axis_tready),
		.avg_raw         (avg_raw),
		.avg_millivolts  (avg_millivolts),
		.min_raw         (min_raw),
		.max_raw         (max_raw),
		.calibration_ok  (calibration_ok),
		.moisture_percent(moisture_percent),
		.moisture_band   (moisture_band)
	);

	// result beat packing
	assign m_axis_tvalid = out_valid;
	assign m_axis_tdata  = OUT_W'({moisture_band, moisture_percent, calibration_ok,
		max_raw, min_raw, avg_millivolts, avg_raw});

endmodule

`default_nettype wire

// ----- rtl/core/amc_checker.sv -----
// ----------------------------------------------------------------------------
// amc_checker - port checks of the moisture calibrator
// Watches the top-level ports and flags result beats that break the
// calibration rules or the stream handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module amc_checker #(
	parameter int SAMPLE_BITS = amc_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    s_axis_tvalid,
	input  wire logic                                    s_axis_tready,
	input  wire logic [((SAMPLE_BITS + 12 + 7) / 8) * 8 - 1:0] s_axis_tdata,
	input  wire logic                                    m_axis_tvalid,
	input  wire logic                                    m_axis_tready,
	input  wire logic [((3 * SAMPLE_BITS + 23 + 7) / 8) * 8 - 1:0] m_axis_tdata,
	input  wire logic                                    cfg_we,
	input  wire logic [amc_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [SAMPLE_BITS-1:0]                  cfg_wdata
);
	import amc_pkg::*;

	localparam int S = SAMPLE_BITS;

	logic [S-1:0]        avg_raw, min_raw, max_raw;
	logic                ok;
	logic [PCT_BITS-1:0] pct;
	logic [1:0]          band;
	logic                unused_ok;

	assign avg_raw = m_axis_tdata[0 +: S];
	assign min_raw = m_axis_tdata[S + MV_BITS +: S];
	assign max_raw = m_axis_tdata[2 * S + MV_BITS +: S];
	assign ok      = m_axis_tdata[3 * S + MV_BITS];
	assign pct     = m_axis_tdata[3 * S + MV_BITS + 1 +: PCT_BITS];
	assign band    = m_axis_tdata[3 * S + MV_BITS + 1 + PCT_BITS +: 2];

	// input side and register port carry nothing checked here
	assign unused_ok = ^{s_axis_tvalid, s_axis_tready, s_axis_tdata, cfg_we, cfg_index,
		cfg_wdata};

	// uncalibrated results carry the fixed marker values
	a_uncal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !ok |-> pct == PCT_UNCAL && band == BAND_UNCAL)
		else $error("uncalibrated result without marker values");

	// calibrated results are in range and banded by their percentage
	a_cal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ok |-> pct <= PCT_BITS'(FULL_SCALE)
			&& band == band_of(pct[PCT_MAG_BITS-1:0]))
		else $error("calibrated percentage or band inconsistent");

	// the batch mean lies between the batch extremes
	a_mean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> min_raw <= avg_raw && avg_raw <= max_raw)
		else $error("mean raw code outside batch extremes");

	// a stalled result beat is neither dropped nor altered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result beat changed");

endmodule

bind averaged_moisture_calibrator_top amc_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_amc_checker (.*);

`default_nettype wire
